### sv/lcrc_pkg.sv
// Shared types and constants for the leader clustering block.
// Used by the top level and the iterative divider; no dependencies.
package lcrc_pkg;

	localparam int CoordW     = 16;
	localparam int CountW     = 16;
	localparam int RadiusW    = 16;
	localparam int GroupIdxW  = 4;
	localparam int ColorW     = 3;
	localparam int MulW       = CoordW + 1;
	localparam int ProdW      = 2 * MulW;
	localparam int DvdW       = 33;
	localparam int DivSteps   = 32;
	localparam int DivStepW   = $clog2(DivSteps);

	localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(1600);
	localparam logic [CountW-1:0]  CountMax    = '1;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic [CountW-1:0]        count_t;

	// start pulse with operands; the dividend is signed, the divisor is nonzero
	typedef struct packed {
		logic                   start;
		logic signed [DvdW-1:0] dividend;
		count_t                 divisor;
	} div_req_t;

	// done pulses for one cycle while quotient is valid
	typedef struct packed {
		logic   done;
		coord_t quotient;
	} div_rsp_t;

endpackage

### sv/lcrc_div.sv
// Radix-2 restoring divider, signed dividend over unsigned count, truncating.
// Depends on lcrc_pkg.
module lcrc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lcrc_pkg::div_req_t req,
	output lcrc_pkg::div_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic                                neg_q;
	logic [lcrc_pkg::DivStepW-1:0]       step_q;
	logic [lcrc_pkg::CountW-1:0]         dvs_q;
	logic [lcrc_pkg::CountW-1:0]         rem_q;
	logic [lcrc_pkg::DivSteps-1:0]       quo_q;

	logic [lcrc_pkg::DvdW-1:0]           mag;
	logic [lcrc_pkg::CountW:0]           rem_sh;
	logic                                fits;
	logic [lcrc_pkg::DivSteps-1:0]       quo_neg;

	assign mag    = req.dividend[lcrc_pkg::DvdW-1] ? (lcrc_pkg::DvdW'(0) - req.dividend)
	                                                : req.dividend;
	assign rem_sh = {rem_q, quo_q[lcrc_pkg::DivSteps-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};
	assign quo_neg = lcrc_pkg::DivSteps'(0) - quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == lcrc_pkg::DivStepW'(lcrc_pkg::DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: magnitude shifts out of quo_q while quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[lcrc_pkg::DvdW-1];
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= mag[lcrc_pkg::DivSteps-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? lcrc_pkg::CountW'(rem_sh - {1'b0, dvs_q})
			              : rem_sh[lcrc_pkg::CountW-1:0];
			quo_q <= {quo_q[lcrc_pkg::DivSteps-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? quo_neg[lcrc_pkg::CoordW-1:0]
	                            : quo_q[lcrc_pkg::CoordW-1:0];

endmodule

### sv/leader_clustering_running_centroid.sv
// Leader clustering of 2-D Q12.4 points with running centroids, top level.
// Depends on lcrc_pkg and lcrc_div.
//
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ---------------------------------------
// input     in         in_valid / in_stall    mode, point_x, point_y
// result    out        out_valid / out_stall  group_index, opened_new, table_full,
//                                             color_index, centroid_x, centroid_y
// config    in         cfg_we                 cfg_wdata (join_radius)
//
// Sequence, from the accept cycle through the state that loads the output register:
//   a clear goes straight to the push state. A classify on an empty table opens a
//   group directly; otherwise it forms radius^2, then scans the groups (read,
//   dx^2, dy^2, compare per group through one shared 17x17 multiplier), then
//   opens a group or flags a full table, or joins one: two centroid updates, each
//   a multiply, an add and a 32-step divide that ends with its done pulse. The
//   longest case is a join on the 16th group.
// Reset clears the sequencer, the output valid flag, the group count and the radius (to 1600); the
//   group table itself is not cleared, entries at or above the count are never read.
// in_stall is high while an item is in work; a finished result waits in the
//   output register, and the next transaction is taken while it is stalled.
module leader_clustering_running_centroid #(
	parameter int MAX_GROUPS   = 16,
	parameter int PALETTE_SIZE = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lcrc_pkg::RadiusW-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic signed [lcrc_pkg::CoordW-1:0]  point_x,
	input  logic signed [lcrc_pkg::CoordW-1:0]  point_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lcrc_pkg::GroupIdxW-1:0]      group_index,
	output logic                                opened_new,
	output logic                                table_full,
	output logic [lcrc_pkg::ColorW-1:0]         color_index,
	output logic signed [lcrc_pkg::CoordW-1:0]  centroid_x,
	output logic signed [lcrc_pkg::CoordW-1:0]  centroid_y
);

	localparam int CntW = $clog2(MAX_GROUPS + 1);
	localparam int IdxW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int ColW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

	typedef struct packed {
		lcrc_pkg::coord_t cx;
		lcrc_pkg::coord_t cy;
		lcrc_pkg::count_t cnt;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_R2, S_READ, S_DX, S_DY, S_CMP, S_MX, S_AX, S_WX,
		S_MY, S_AY, S_WY, S_NEW, S_PUSH
	} state_t;

	state_t                          state_q;
	logic [lcrc_pkg::RadiusW-1:0]    join_radius_q;
	logic [CntW-1:0]                 groups_used_q;
	logic [CntW-1:0]                 idx_q;
	logic [ColW-1:0]                 color_q;
	lcrc_pkg::coord_t                px_q;
	lcrc_pkg::coord_t                py_q;
	logic [2*lcrc_pkg::RadiusW-1:0]  r2_q;
	logic [lcrc_pkg::ProdW-2:0]      d2_q;
	lcrc_pkg::count_t                n_q;
	lcrc_pkg::coord_t                qx_q;

	// group table, one word per group
	entry_t                          mem_q [MAX_GROUPS];
	entry_t                          rd_q;
	logic                            mem_we;
	entry_t                          mem_wdata;

	// shared multiplier, product registered
	logic signed [lcrc_pkg::MulW-1:0]  mul_a;
	logic signed [lcrc_pkg::MulW-1:0]  mul_b;
	logic signed [lcrc_pkg::ProdW-1:0] prod_q;

	// pending result, then output register
	logic [lcrc_pkg::GroupIdxW-1:0]  res_idx_q;
	logic                            res_opened_q;
	logic                            res_full_q;
	logic [lcrc_pkg::ColorW-1:0]     res_color_q;
	lcrc_pkg::coord_t                res_cx_q;
	lcrc_pkg::coord_t                res_cy_q;
	logic                            out_valid_q;
	logic [lcrc_pkg::GroupIdxW-1:0]  out_idx_q;
	logic                            out_opened_q;
	logic                            out_full_q;
	logic [lcrc_pkg::ColorW-1:0]     out_color_q;
	lcrc_pkg::coord_t                out_cx_q;
	lcrc_pkg::coord_t                out_cy_q;

	lcrc_pkg::div_req_t              div_req;
	lcrc_pkg::div_rsp_t              div_rsp;

	logic signed [lcrc_pkg::MulW-1:0] dx;
	logic signed [lcrc_pkg::MulW-1:0] dy;
	logic [lcrc_pkg::ProdW-1:0]       d2_sum;
	logic                             hit;
	lcrc_pkg::count_t                 n_next;
	logic [CntW-1:0]                  idx_next;
	logic                             table_at_max;

	lcrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign dx = {px_q[lcrc_pkg::CoordW-1], px_q} - {rd_q.cx[lcrc_pkg::CoordW-1], rd_q.cx};
	assign dy = {py_q[lcrc_pkg::CoordW-1], py_q} - {rd_q.cy[lcrc_pkg::CoordW-1], rd_q.cy};

	// join test: dx^2 + dy^2 < radius^2, all at full width
	assign d2_sum = {1'b0, d2_q} + {1'b0, prod_q[lcrc_pkg::ProdW-2:0]};
	assign hit    = d2_sum < {2'b00, r2_q};

	assign n_next       = (rd_q.cnt == lcrc_pkg::CountMax) ? rd_q.cnt : rd_q.cnt + 1'b1;
	assign idx_next     = idx_q + 1'b1;
	assign table_at_max = groups_used_q == CntW'(MAX_GROUPS);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_R2: begin
				mul_a = {1'b0, join_radius_q};
				mul_b = {1'b0, join_radius_q};
			end
			S_DX: begin
				mul_a = dx;
				mul_b = dx;
			end
			S_DY: begin
				mul_a = dy;
				mul_b = dy;
			end
			S_MX: begin
				mul_a = {rd_q.cx[lcrc_pkg::CoordW-1], rd_q.cx};
				mul_b = {1'b0, n_q - 1'b1};
			end
			S_MY: begin
				mul_a = {rd_q.cy[lcrc_pkg::CoordW-1], rd_q.cy};
				mul_b = {1'b0, n_q - 1'b1};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// c*(n-1) + p goes to the divider over n
	always_comb begin
		div_req.start    = (state_q == S_AX) || (state_q == S_AY);
		div_req.divisor  = n_q;
		div_req.dividend = prod_q[lcrc_pkg::DvdW-1:0] +
			((state_q == S_AY) ? {{(lcrc_pkg::DvdW-lcrc_pkg::CoordW){py_q[lcrc_pkg::CoordW-1]}}, py_q}
			                   : {{(lcrc_pkg::DvdW-lcrc_pkg::CoordW){px_q[lcrc_pkg::CoordW-1]}}, px_q});
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '{cx: px_q, cy: py_q, cnt: lcrc_pkg::CountW'(1)};
		if (state_q == S_WY && div_rsp.done) begin
			mem_we    = 1'b1;
			mem_wdata = '{cx: qx_q, cy: div_rsp.quotient, cnt: n_q};
		end else if (state_q == S_NEW && !table_at_max) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[idx_q[IdxW-1:0]] <= mem_wdata;
		end
		if (state_q == S_READ) begin
			rd_q <= mem_q[idx_q[IdxW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			join_radius_q <= lcrc_pkg::RadiusReset;
		end else if (cfg_we) begin
			join_radius_q <= cfg_wdata;
		end
	end

	// sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			groups_used_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// the push state reloads the output register itself
			if (out_valid_q && !out_stall && state_q != S_PUSH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					idx_q        <= '0;
					color_q      <= '0;
					px_q         <= point_x;
					py_q         <= point_y;
					res_idx_q    <= '0;
					res_opened_q <= 1'b0;
					res_full_q   <= 1'b0;
					res_color_q  <= '0;
					res_cx_q     <= '0;
					res_cy_q     <= '0;
					if (in_valid) begin
						if (mode) begin
							groups_used_q <= '0;
							state_q       <= S_PUSH;
						end else if (groups_used_q == '0) begin
							state_q <= S_NEW;
						end else begin
							state_q <= S_R2;
						end
					end
				end
				S_R2: state_q <= S_READ;
				S_READ: begin
					if (idx_q == '0) begin
						r2_q <= prod_q[2*lcrc_pkg::RadiusW-1:0];
					end
					state_q <= S_DX;
				end
				S_DX: state_q <= S_DY;
				S_DY: begin
					d2_q    <= prod_q[lcrc_pkg::ProdW-2:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						n_q     <= n_next;
						state_q <= S_MX;
					end else begin
						idx_q   <= idx_next;
						color_q <= (color_q == ColW'(PALETTE_SIZE - 1)) ? '0 : color_q + 1'b1;
						state_q <= (idx_next == groups_used_q) ? S_NEW : S_READ;
					end
				end
				S_MX: state_q <= S_AX;
				S_AX: state_q <= S_WX;
				S_WX: begin
					if (div_rsp.done) begin
						qx_q    <= div_rsp.quotient;
						state_q <= S_MY;
					end
				end
				S_MY: state_q <= S_AY;
				S_AY: state_q <= S_WY;
				S_WY: begin
					if (div_rsp.done) begin
						res_idx_q   <= lcrc_pkg::GroupIdxW'(idx_q);
						res_color_q <= lcrc_pkg::ColorW'(color_q);
						res_cx_q    <= qx_q;
						res_cy_q    <= div_rsp.quotient;
						state_q     <= S_PUSH;
					end
				end
				S_NEW: begin
					if (table_at_max) begin
						res_full_q <= 1'b1;
					end else begin
						groups_used_q <= groups_used_q + 1'b1;
						res_idx_q     <= lcrc_pkg::GroupIdxW'(idx_q);
						res_opened_q  <= 1'b1;
						res_color_q   <= lcrc_pkg::ColorW'(color_q);
						res_cx_q      <= px_q;
						res_cy_q      <= py_q;
					end
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_idx_q    <= res_idx_q;
						out_opened_q <= res_opened_q;
						out_full_q   <= res_full_q;
						out_color_q  <= res_color_q;
						out_cx_q     <= res_cx_q;
						out_cy_q     <= res_cy_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign group_index = out_idx_q;
	assign opened_new  = out_opened_q;
	assign table_full  = out_full_q;
	assign color_index = out_color_q;
	assign centroid_x  = out_cx_q;
	assign centroid_y  = out_cy_q;

endmodule
